FILE: hdl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    // fixed point: c is signed Q4.28, z is signed Q2.28
    localparam int FRAC_BITS = 28;
    localparam int C_W       = 32;
    localparam int Z_W       = 30;   // |Re z|, |Im z| < 2.0 while iterating
    localparam int STEP_W    = 29;
    localparam int COORD_W   = 10;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = 20;
    localparam int PROD_W    = 2 * Z_W;
    localparam int ACC_W     = PROD_W + 2;

    localparam int Q_DEPTH   = 2;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_ORIGIN_REAL = 2'd0,
        REG_ORIGIN_IMAG = 2'd1,
        REG_PIXEL_STEP  = 2'd2,
        REG_ITER_LIMIT  = 2'd3
    } t_reg_idx;

    localparam logic [C_W-1:0]    RST_ORIGIN_REAL = 32'hE000_0000;
    localparam logic [C_W-1:0]    RST_ORIGIN_IMAG = 32'hE800_0000;
    localparam logic [STEP_W-1:0] RST_PIXEL_STEP  = 29'd786432;
    localparam logic [CNT_W-1:0]  RST_ITER_LIMIT  = 16'd1000;

    typedef struct packed {
        logic signed [C_W-1:0] origin_real;
        logic signed [C_W-1:0] origin_imag;
        logic [STEP_W-1:0]     pixel_step;
        logic [CNT_W-1:0]      iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
        logic [IDX_W-1:0]      pixel_index;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: hdl/mbe_if.sv
`default_nettype none

interface mbe_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] escape_count;
    logic [19:0] pixel_index;

    modport source (output valid, output escape_count, output pixel_index, input ready);
    modport sink   (input valid, input escape_count, input pixel_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/mbe_queue.sv
`default_nettype none

module mbe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbe_pkg::t_job   i_job,
    input  logic            i_pop,
    output mbe_pkg::t_job   o_job,
    output mbe_pkg::t_q_stat o_stat
);
    import mbe_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(Q_DEPTH + 1);

    t_job               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W_Q-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    always_comb begin
        n_wr  = i_push ? f_inc(r_wr) : r_wr;
        n_rd  = i_pop  ? f_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CNT_W_Q'(i_push) - CNT_W_Q'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W_Q'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

FILE: hdl/mbe_front.sv
`default_nettype none

module mbe_front #(
    parameter int IMAGE_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mbe_pix_if.sink          i_pix,
    input  mbe_pkg::t_cfg    i_cfg,
    input  mbe_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output mbe_pkg::t_job    o_job
);
    import mbe_pkg::*;

    localparam int MAP_W = STEP_W + COORD_W;
    localparam int SUM_W = MAP_W + 2;

    logic             r_v, n_v;
    logic [MAP_W-1:0] r_prod_re;
    logic [MAP_W-1:0] r_prod_im;
    logic [IDX_W-1:0] r_index;
    logic             accept;

    // origin + offset, clamped to the signed 32-bit range
    function automatic logic signed [C_W-1:0] f_map(
        input logic signed [C_W-1:0] origin,
        input logic [MAP_W-1:0]      offs
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [C_W-1:0]   res;
        sum = $signed({{(SUM_W-C_W){origin[C_W-1]}}, origin})
            + $signed({2'b00, offs});
        if (!sum[SUM_W-1] && (|sum[SUM_W-2:C_W-1])) begin
            res = {1'b0, {(C_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:C_W-1])) begin
            res = {1'b1, {(C_W-1){1'b0}}};
        end else begin
            res = sum[C_W-1:0];
        end
        return res;
    endfunction

    assign i_pix.ready = !r_v || !i_q_stat.full;
    assign accept      = i_pix.valid && i_pix.ready;
    assign o_push      = r_v && !i_q_stat.full;

    always_comb begin
        n_v = r_v;
        if (accept) begin
            n_v = 1'b1;
        end else if (o_push) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_re <= MAP_W'(i_cfg.pixel_step) * MAP_W'(i_pix.pixel_col);
            r_prod_im <= MAP_W'(i_cfg.pixel_step) * MAP_W'(i_pix.pixel_row);
            r_index   <= IDX_W'(IDX_W'(i_pix.pixel_row) * IDX_W'(IMAGE_WIDTH)
                                + IDX_W'(i_pix.pixel_col));
        end
    end

    assign o_job.cr          = f_map(i_cfg.origin_real, r_prod_re);
    assign o_job.ci          = f_map(i_cfg.origin_imag, r_prod_im);
    assign o_job.pixel_index = r_index;

endmodule

`default_nettype wire

FILE: hdl/mbe_core.sv
`default_nettype none

module mbe_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mbe_pkg::CNT_W-1:0] i_iter_limit,
    input  mbe_pkg::t_job            i_job,
    input  mbe_pkg::t_q_stat         i_q_stat,
    output logic                     o_pop,
    mbe_res_if.source                o_res
);
    import mbe_pkg::*;

    localparam int NZ_W   = ACC_W - FRAC_BITS;
    localparam int MAG_W  = PROD_W + 1;
    localparam logic [MAG_W-1:0] FOUR_SQ = MAG_W'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [NZ_W-1:0] Z_HI = NZ_W'(2 ** (Z_W - 1));
    localparam logic signed [NZ_W-1:0] Z_LO = -Z_HI;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic signed [C_W-1:0]    r_cr, r_ci;
    logic [IDX_W-1:0]         r_index;
    logic signed [Z_W-1:0]    r_zr, n_zr;
    logic signed [Z_W-1:0]    r_zi, n_zi;
    logic [CNT_W-1:0]         r_iter, n_iter;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri;
    logic                     r_out_v, n_out_v;
    logic [CNT_W-1:0]         r_out_count;
    logic [IDX_W-1:0]         r_out_index;

    logic [MAG_W-1:0]         sq_sum;
    logic signed [ACC_W-1:0]  acc_re, acc_im;
    logic signed [NZ_W-1:0]   nr, ni;
    logic                     esc_mag, esc_abs, at_limit, out_load;
    logic [CNT_W-1:0]         limit_cnt;

    // squares of the held z give the magnitude test for it and the next z
    assign sq_sum  = MAG_W'(unsigned'(r_p_rr)) + MAG_W'(unsigned'(r_p_ii));
    assign esc_mag = (r_iter != '0) && (sq_sum >= FOUR_SQ);

    assign acc_re = ACC_W'(r_p_rr) - ACC_W'(r_p_ii) + (ACC_W'(r_cr) <<< FRAC_BITS);
    assign acc_im = (ACC_W'(r_p_ri) <<< 1) + (ACC_W'(r_ci) <<< FRAC_BITS);
    assign nr     = acc_re[ACC_W-1:FRAC_BITS];
    assign ni     = acc_im[ACC_W-1:FRAC_BITS];
    assign esc_abs = (nr >= Z_HI) || (nr <= Z_LO) || (ni >= Z_HI) || (ni <= Z_LO);

    assign at_limit  = (r_iter == i_iter_limit);
    assign limit_cnt = (&i_iter_limit) ? i_iter_limit : i_iter_limit + CNT_W'(1);

    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == S_DONE) && (!r_out_v || o_res.ready);

    always_comb begin
        n_state = r_state;
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_iter  = r_iter;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_zr    = '0;
                    n_zi    = '0;
                    n_iter  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                priority if (esc_mag) begin
                    n_count = r_iter;
                    n_state = S_DONE;
                end else if (at_limit) begin
                    n_count = limit_cnt;
                    n_state = S_DONE;
                end else begin
                    n_zr   = nr[Z_W-1:0];
                    n_zi   = ni[Z_W-1:0];
                    n_iter = r_iter + CNT_W'(1);
                    if (esc_abs) begin
                        n_count = r_iter + CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_v = r_out_v;
        if (out_load) begin
            n_out_v = 1'b1;
        end else if (o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_iter  <= n_iter;
        r_count <= n_count;
        if (o_pop) begin
            r_cr    <= i_job.cr;
            r_ci    <= i_job.ci;
            r_index <= i_job.pixel_index;
        end
        if (r_state == S_MUL) begin
            r_p_rr <= r_zr * r_zr;
            r_p_ii <= r_zi * r_zi;
            r_p_ri <= r_zr * r_zi;
        end
        if (out_load) begin
            r_out_count <= r_count;
            r_out_index <= r_index;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.escape_count = r_out_count;
    assign o_res.pixel_index  = r_out_index;

endmodule

`default_nettype wire

FILE: hdl/mandelbrot_escape_time.sv
// A pixel beat is registered by the front, waits in the queue, then the core iterates
//   until z leaves the |Re|,|Im| < 2 box, escapes on |z|^2 >= 4, or reaches the limit.
// Each z = z^2 + c step takes a multiply state and an add/compare state; the core pops
//   the next pixel only after its output register has taken the last result.
// Reset: i_rst_n synchronous, active low; clears the handshake state and the queue and
//   loads the registers with origin -2.0 - 1.5i, step 786432, limit 1000.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int IMAGE_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbe_pix_if.sink     i_pix,
    mbe_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbe_pkg::*;

    // Front: takes a pixel beat, forms step*col / step*row and the linear index,
    // then adds the origin with clamping as the job enters the queue.
    // Queue: two jobs deep, so the front keeps taking pixels while the core iterates.
    // Core: iterates z = z^2 + c, z in Q2.28 and c in Q4.28, squares kept exact in 60 bits,
    // and holds the result in an output register so the next job can start behind it.

    t_cfg     r_cfg, n_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    t_job     front_job, queue_job;
    t_q_stat  q_stat;
    logic     push, pop;

    // config port: no wait states, write lands on the access cycle
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_ORIGIN_REAL: n_cfg.origin_real     = pwdata;
                REG_ORIGIN_IMAG: n_cfg.origin_imag     = pwdata;
                REG_PIXEL_STEP:  n_cfg.pixel_step      = pwdata[STEP_W-1:0];
                REG_ITER_LIMIT:  n_cfg.iteration_limit = pwdata[CNT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real     <= RST_ORIGIN_REAL;
            r_cfg.origin_imag     <= RST_ORIGIN_IMAG;
            r_cfg.pixel_step      <= RST_PIXEL_STEP;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back: registers zero-extended to the bus
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_REAL: prdata = r_cfg.origin_real;
            REG_ORIGIN_IMAG: prdata = r_cfg.origin_imag;
            REG_PIXEL_STEP:  prdata = 32'(r_cfg.pixel_step);
            REG_ITER_LIMIT:  prdata = 32'(r_cfg.iteration_limit);
            default:         prdata = '0;
        endcase
    end

    mbe_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (front_job)
    );

    mbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (q_stat)
    );

    mbe_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_iter_limit (r_cfg.iteration_limit),
        .i_job        (queue_job),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

FILE: hdl/mbe_checker.sv
`default_nettype none

module mbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_escape_count,
    input logic [19:0] i_pixel_index
);

    // reset empties the output register
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result beat shown right after reset");

    // counts start at one
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_escape_count != 16'd0))
        else $error("escape count of zero");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result beat dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> ($stable(i_escape_count) && $stable(i_pixel_index)))
        else $error("result payload changed while stalled");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_escape_count (o_res.escape_count),
    .i_pixel_index  (o_res.pixel_index)
);

`default_nettype wire
